// ===== hw/rtl/e2q_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants and functions for the euler to quaternion block
// holds the cordic arctangent function and fixed-point helpers
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int TRIG_STAGES     = 16;
    localparam int IN_W            = 16;
    localparam int OUT_W           = OUT_FRAC_BITS + 2;
    localparam int MAX_STAGES      = 48;

    // cordic working widths: z in Q48, x/y in Q40
    localparam int ZW = 52;
    localparam int XW = 43;
    // trig results Q30
    localparam int TW = 32;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [42:0] GAIN_Q40 = 43'd667681663043;
    // floor(pi_q48 / 360), pi in Q48 is PI_Q60 >> 12
    localparam logic [63:0] PER_Q48  = (PI_Q60 >> 12) / 360;

    typedef logic signed [ZW-1:0] t_z;
    typedef logic signed [XW-1:0] t_xy;
    typedef logic signed [TW-1:0] t_trig;

    // atan(2^-i) in Q48, evaluated at elaboration for constant i
    function automatic logic signed [ZW-1:0] atan_q48(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int d;
        sum = 64'sd0;
        if (i == 0) begin
            return ZW'(PI_Q60 >> 14);
        end
        for (int k = 0; k < 63; k++) begin
            d = 2 * k + 1;
            if (i * d <= 62) begin
                term = $signed(64'((64'd1 << (62 - i * d)) / 64'(d)));
                if ((k & 1) != 0) sum = sum - term;
                else sum = sum + term;
            end
        end
        return ZW'((sum + 64'sd8192) >>> 14);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/e2q_wrap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_wrap: angle wrap and degree to radian scaling
// wraps the angle into one turn and forms the Q48 half angle in radians
// ----------------------------------------------------------------------------
module e2q_wrap (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [e2q_pkg::IN_W-1:0] i_angle,
    output logic signed [e2q_pkg::ZW-1:0]    o_z
);
    localparam int AW = e2q_pkg::IN_W + 2;
    localparam int PW = 44;
    localparam logic signed [AW-1:0] HALF = AW'(180 << e2q_pkg::ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] FULL = AW'(360 << e2q_pkg::ANGLE_FRAC_BITS);
    localparam logic signed [PW-1:0] PER  = PW'(e2q_pkg::PER_Q48);

    logic signed [AW-1:0] a_ext;
    logic signed [AW-1:0] wrapped;
    logic signed [AW-1:0] r_a;
    logic signed [AW+PW-1:0] prod;
    logic signed [AW+PW-1:0] magn;
    logic signed [AW+PW-1:0] quo;

    // input range is under one turn either side, one add or subtract fixes it
    always_comb begin
        a_ext = AW'(i_angle);
        if (a_ext > HALF) begin
            wrapped = a_ext - FULL;
            if (wrapped > HALF) wrapped = wrapped - FULL;
        end else if (a_ext < -HALF) begin
            wrapped = a_ext + FULL;
            if (wrapped < -HALF) wrapped = wrapped + FULL;
        end else begin
            wrapped = a_ext;
        end
        // c wrap keeps +-180 exactly only inside range; -180 stays -180
        if (wrapped == HALF && (a_ext != HALF)) wrapped = -HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_a <= wrapped;
    end

    // truncating divide toward zero by a power of two
    always_comb begin
        prod = (AW+PW)'(r_a) * (AW+PW)'(PER);
        magn = prod[AW+PW-1] ? -prod : prod;
        quo  = magn >>> e2q_pkg::ANGLE_FRAC_BITS;
        if (prod[AW+PW-1]) quo = -quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_z <= e2q_pkg::ZW'(quo);
    end
endmodule
`default_nettype wire

// ===== hw/rtl/e2q_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined rotation-mode cordic
// one register stage per iteration, cos and sin rounded to Q30
// ----------------------------------------------------------------------------
module e2q_cordic #(
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire e2q_pkg::t_z       i_z,
    output e2q_pkg::t_trig         o_cos,
    output e2q_pkg::t_trig         o_sin
);
    localparam int N = (TRIG_STAGES > e2q_pkg::MAX_STAGES) ? e2q_pkg::MAX_STAGES
                                                          : TRIG_STAGES;

    e2q_pkg::t_xy r_x [1:N];
    e2q_pkg::t_xy r_y [1:N];
    e2q_pkg::t_z  r_z [1:N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam e2q_pkg::t_z ATAN = e2q_pkg::atan_q48(i);
        e2q_pkg::t_xy x_i, y_i, dx, dy;
        e2q_pkg::t_z  z_i;
        // first stage starts from the gain-corrected unit vector
        if (i == 0) begin : g_in
            assign x_i = e2q_pkg::GAIN_Q40;
            assign y_i = '0;
            assign z_i = i_z;
        end else begin : g_mid
            assign x_i = r_x[i];
            assign y_i = r_y[i];
            assign z_i = r_z[i];
        end
        assign dx = y_i >>> i;
        assign dy = x_i >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_i[e2q_pkg::ZW-1]) begin
                    r_x[i+1] <= x_i - dx;
                    r_y[i+1] <= y_i + dy;
                    r_z[i+1] <= z_i - ATAN;
                end else begin
                    r_x[i+1] <= x_i + dx;
                    r_y[i+1] <= y_i - dy;
                    r_z[i+1] <= z_i + ATAN;
                end
            end
        end
    end

    e2q_pkg::t_xy xr, yr;
    assign xr = r_x[N] + e2q_pkg::XW'(512);
    assign yr = r_y[N] + e2q_pkg::XW'(512);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= e2q_pkg::TW'(xr >>> 10);
            o_sin <= e2q_pkg::TW'(yr >>> 10);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/e2q_combine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_combine: quaternion assembly from half-angle trig values
// pair products, triple products, sum and round with saturation
// ----------------------------------------------------------------------------
module e2q_combine (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire e2q_pkg::t_trig  i_c1, i_s1, i_c2, i_s2, i_c3, i_s3,
    output logic signed [e2q_pkg::OUT_W-1:0] o_w, o_x, o_y, o_z
);
    localparam int OW = e2q_pkg::OUT_W;
    localparam int SH = 60 - e2q_pkg::OUT_FRAC_BITS;
    localparam logic signed [63:0] LIM = 64'sd1 <<< e2q_pkg::OUT_FRAC_BITS;

    // pairs: c1c2, s1s2, s1c2, c1s2 rounded to Q30
    logic signed [63:0] r_p [0:3];
    e2q_pkg::t_trig r_c3a, r_s3a;
    logic signed [31:0] p30 [0:3];
    logic signed [63:0] r_t [0:7];
    logic signed [63:0] r_q [0:3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= 64'(i_c1) * 64'(i_c2);
            r_p[1] <= 64'(i_s1) * 64'(i_s2);
            r_p[2] <= 64'(i_s1) * 64'(i_c2);
            r_p[3] <= 64'(i_c1) * 64'(i_s2);
            r_c3a  <= i_c3;
            r_s3a  <= i_s3;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_rnd
        logic signed [63:0] t;
        assign t = (r_p[k] + 64'sd536870912) >>> 30;
        assign p30[k] = 32'(t);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= 64'(p30[0]) * 64'(r_c3a); // c1c2c3
            r_t[1] <= 64'(p30[1]) * 64'(r_s3a); // s1s2s3
            r_t[2] <= 64'(p30[1]) * 64'(r_c3a); // s1s2c3
            r_t[3] <= 64'(p30[0]) * 64'(r_s3a); // c1c2s3
            r_t[4] <= 64'(p30[2]) * 64'(r_c3a); // s1c2c3
            r_t[5] <= 64'(p30[3]) * 64'(r_s3a); // c1s2s3
            r_t[6] <= 64'(p30[3]) * 64'(r_c3a); // c1s2c3
            r_t[7] <= 64'(p30[2]) * 64'(r_s3a); // s1c2s3
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= r_t[0] - r_t[1];
            r_q[1] <= r_t[2] + r_t[3];
            r_q[2] <= r_t[4] + r_t[5];
            r_q[3] <= r_t[6] - r_t[7];
        end
    end

    logic signed [OW-1:0] fin [0:3];
    for (genvar k = 0; k < 4; k++) begin : g_fin
        logic signed [63:0] r;
        always_comb begin
            r = (r_q[k] + (64'sd1 <<< (SH - 1))) >>> SH;
            if (r > LIM) r = LIM;
            if (r < -LIM) r = -LIM;
            fin[k] = OW'(r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= fin[0];
            o_x <= fin[1];
            o_y <= fin[2];
            o_z <= fin[3];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/euler_to_quaternion.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion: three euler angles in degrees to a Q1.14 quaternion
// registers in order: wrap, scale, one per cordic iteration, trig round,
// pair product, triple product, sum, round; one word per cycle while
// not stalled, set by the fully pipelined cordic and multiplier stages.
// the whole pipe freezes on stall. synchronous active-low reset clears
// the valid bits only.
module euler_to_quaternion #(
    parameter int TRIG_STAGES     = e2q_pkg::TRIG_STAGES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_angle_a_deg,
    input  wire logic signed [15:0] i_angle_b_deg,
    input  wire logic signed [15:0] i_angle_c_deg,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [e2q_pkg::OUT_W-1:0] o_quat_w,
    output logic signed [e2q_pkg::OUT_W-1:0] o_quat_x,
    output logic signed [e2q_pkg::OUT_W-1:0] o_quat_y,
    output logic signed [e2q_pkg::OUT_W-1:0] o_quat_z
);
    localparam int NS  = (TRIG_STAGES > e2q_pkg::MAX_STAGES) ? e2q_pkg::MAX_STAGES
                                                            : TRIG_STAGES;
    localparam int LAT = NS + 7;

    logic r_v [0:LAT-1];
    logic en;

    // pipe advances unless a finished word is held at the output
    assign en      = !(r_v[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    e2q_pkg::t_z    za, zb, zc;
    e2q_pkg::t_trig c1, s1, c2, s2, c3, s3;

    e2q_wrap u_wrap_a (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_a_deg), .o_z(za));
    e2q_wrap u_wrap_b (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_b_deg), .o_z(zb));
    e2q_wrap u_wrap_c (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_c_deg), .o_z(zc));

    e2q_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic_a (
        .i_clk(i_clk), .i_en(en), .i_z(za), .o_cos(c1), .o_sin(s1));
    e2q_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic_b (
        .i_clk(i_clk), .i_en(en), .i_z(zb), .o_cos(c2), .o_sin(s2));
    e2q_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic_c (
        .i_clk(i_clk), .i_en(en), .i_z(zc), .o_cos(c3), .o_sin(s3));

    e2q_combine u_combine (
        .i_clk(i_clk), .i_en(en),
        .i_c1(c1), .i_s1(s1), .i_c2(c2), .i_s2(s2), .i_c3(c3), .i_s3(s3),
        .o_w(o_quat_w), .o_x(o_quat_x), .o_y(o_quat_y), .o_z(o_quat_z));
endmodule
`default_nettype wire

// ===== test/e2q_checker.sv =====
// ----------------------------------------------------------------------------
// e2q_checker: scoreboard for the euler to quaternion block
// watches both channels, predicts each quaternion from the accepted angles
// and compares it field by field with the words that come out
// ----------------------------------------------------------------------------
module e2q_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic signed [15:0] i_angle_a,
    input  wire logic signed [15:0] i_angle_b,
    input  wire logic signed [15:0] i_angle_c,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output int                      o_errors,
    output int                      o_pending,
    output logic                    o_moved
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AFRAC = e2q_pkg::ANGLE_FRAC_BITS;
    localparam int OFRAC = e2q_pkg::OUT_FRAC_BITS;
    localparam int NSTG  = (e2q_pkg::TRIG_STAGES > e2q_pkg::MAX_STAGES) ?
                           e2q_pkg::MAX_STAGES : e2q_pkg::TRIG_STAGES;
    localparam longint PI60 = 64'sh3243F6A8885A308D;
    localparam longint GAIN40 = 64'sd667681663043;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    t_quat expected_quats[$];
    int    mismatches;

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint arctan_q48(int i);
        longint sum;
        longint term;
        int d;
        sum = 0;
        if (i == 0) return PI60 >>> 14;
        for (int k = 0; k < 63; k++) begin
            d = 2 * k + 1;
            if (i * d <= 62) begin
                term = longint'((64'd1 << (62 - i * d)) / 64'(d));
                sum = (k % 2 != 0) ? sum - term : sum + term;
            end
        end
        return round_shift(sum, 14);
    endfunction

    // cosine and sine of half the angle, Q30
    function automatic void half_angle_trig(input logic signed [15:0] raw,
                                            output longint cs, output longint sn);
        longint ang, half, full, r, zr, xr, yr, dx, dy, t;
        half = 180 <<< AFRAC;
        full = 360 <<< AFRAC;
        ang = longint'(raw);
        if (ang < -half || ang > half) begin
            r = (ang + half) % full;
            if (r < 0) r += full;
            ang = r - half;
        end
        zr = (ang * ((PI60 >>> 12) / 360)) / (64'sd1 <<< AFRAC);
        xr = GAIN40;
        yr = 0;
        for (int i = 0; i < NSTG; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            t = arctan_q48(i);
            if (zr >= 0) begin
                xr -= dx; yr += dy; zr -= t;
            end else begin
                xr += dx; yr -= dy; zr += t;
            end
        end
        cs = round_shift(xr, 10);
        sn = round_shift(yr, 10);
    endfunction

    function automatic longint triple(longint a, longint b, longint c);
        return round_shift(a * b, 30) * c;
    endfunction

    function automatic logic signed [15:0] to_q14(longint v);
        longint r, lim;
        lim = 64'sd1 <<< OFRAC;
        r = round_shift(v, 60 - OFRAC);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return 16'(r);
    endfunction

    function automatic t_quat predict_quat(logic signed [15:0] a,
                                           logic signed [15:0] b,
                                           logic signed [15:0] c);
        longint c1, s1, c2, s2, c3, s3;
        t_quat q;
        half_angle_trig(a, c1, s1);
        half_angle_trig(b, c2, s2);
        half_angle_trig(c, c3, s3);
        q.w = to_q14(triple(c1, c2, c3) - triple(s1, s2, s3));
        q.x = to_q14(triple(s1, s2, c3) + triple(c1, c2, s3));
        q.y = to_q14(triple(s1, c2, c3) + triple(c1, s2, s3));
        q.z = to_q14(triple(c1, s2, c3) - triple(s1, c2, s3));
        return q;
    endfunction

    assign o_errors  = mismatches;

    initial mismatches = 0;

    always @(posedge i_clk) begin
        t_quat want, got;
        logic  moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_quats.push_back(predict_quat(i_angle_a, i_angle_b, i_angle_c));
                moved = 1'b1;
            end
            if (i_out_valid && !i_out_stall) begin
                moved = 1'b1;
                got = '{i_quat_w, i_quat_x, i_quat_y, i_quat_z};
                if (expected_quats.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected word: w=%0d x=%0d y=%0d z=%0d",
                                 got.w, got.x, got.y, got.z);
                end else begin
                    want = expected_quats.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"mismatch: exp w=%0d x=%0d y=%0d z=%0d,",
                                      " got w=%0d x=%0d y=%0d z=%0d"},
                                     want.w, want.x, want.y, want.z,
                                     got.w, got.x, got.y, got.z);
                    end
                end
            end
        end
        o_moved   <= moved;
        o_pending <= expected_quats.size();
    end
endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: euler to quaternion testbench
// directed corner angles then random ones across four idle/stall phases,
// checked against an independent predictor in the checker module
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [15:0] i_angle_a_deg = '0;
    logic signed [15:0] i_angle_b_deg = '0;
    logic signed [15:0] i_angle_c_deg = '0;
    logic               o_stall, o_valid;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    int                 errors, pending;
    logic               moved;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;
    int                 words_sent = 0;

    always #5 i_clk = ~i_clk;

    euler_to_quaternion u_top (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_angle_a_deg, .i_angle_b_deg, .i_angle_c_deg,
        .o_valid, .i_stall, .o_quat_w, .o_quat_x, .o_quat_y, .o_quat_z
    );

    e2q_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_angle_a(i_angle_a_deg), .i_angle_b(i_angle_b_deg),
        .i_angle_c(i_angle_c_deg),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_quat_w(o_quat_w), .i_quat_x(o_quat_x),
        .i_quat_y(o_quat_y), .i_quat_z(o_quat_z),
        .o_errors(errors), .o_pending(pending), .o_moved(moved)
    );

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (moved || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG);
            $display("euler_to_quaternion test failed");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_angles(logic signed [15:0] a, logic signed [15:0] b,
                               logic signed [15:0] c);
        bit done;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_angle_a_deg <= a;
        i_angle_b_deg <= b;
        i_angle_c_deg <= c;
        done = 0;
        while (!done) begin
            #1;
            done = !o_stall;
            @(negedge i_clk);
        end
        words_sent++;
    endtask

    function automatic logic signed [15:0] rand_angle();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 16'($signed($urandom_range(46080)) - 23040);
        if (pick < 80) return 16'($signed($urandom_range(8)) * 2880 - 11520);
        return 16'($urandom);
    endfunction

    initial begin
        logic signed [15:0] corners[12];
        corners = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd23041, -16'sd23041,
                    16'sh7fff, -16'sh8000, 16'sd11520, -16'sd11520,
                    16'sd1, -16'sd1, 16'sd5760};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (corners[k]) send_angles(corners[k], corners[(k + 3) % 12],
                                         corners[(k + 7) % 12]);
        send_angles(16'sh5555, -16'sh5556, 16'sh2aaa);
        send_angles(-16'sd23040, -16'sd23040, -16'sd23040);
        send_angles(16'sd23040, 16'sd23040, 16'sd23040);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_angles(-16'sh8000, -16'sh8000, -16'sh8000);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 33 : 0;
            stall_pct = (ph == 2) ? 67 : (ph == 3) ? 33 : 0;
            repeat (258) send_angles(rand_angle(), rand_angle(), rand_angle());
        end
        i_valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (e2q_pkg::TRIG_STAGES + 20) @(negedge i_clk);
        $display("sent %0d angle words: corners, wrapped angles, random mix", words_sent);
        $display("phases: free flow, sender gaps, receiver stalls, both");
        if (errors == 0 && pending == 0) begin
            $display("euler_to_quaternion test passed");
        end else begin
            $display("euler_to_quaternion test failed");
        end
        $finish;
    end
endmodule
